FILE: rtl/core/thp_pkg.sv
// ----------------------------------------------------------------------------
// thp_pkg
// Shared types, constants and helpers for the temperature, pressure and
// humidity compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package thp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_NINE = 3'd3,
    CFG_HUM        = 3'd4,
    CFG_HUM_SIX    = 3'd5
  } cfg_index_t;

  localparam logic [31:0] P_TF_OFFSET   = 32'd64000;
  localparam logic [31:0] P_V1_BIAS     = 32'd32768;
  localparam logic [31:0] P_ADC_BASE    = 32'd1048576;
  localparam logic [31:0] P_SCALE       = 32'd3125;
  localparam logic [31:0] H_TF_OFFSET   = 32'd76800;
  localparam logic [31:0] H_ROUND_A     = 32'd16384;
  localparam logic [31:0] H_BIAS_B      = 32'd32768;
  localparam logic [31:0] H_BIAS_C      = 32'd2097152;
  localparam logic [31:0] H_ROUND_C     = 32'd8192;
  localparam logic [31:0] H_CLAMP       = 32'd419430400;
  localparam logic [31:0] T_ROUND       = 32'd128;

  // One stage of the restoring divider
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dvd;
    logic [31:0] dvs;
    logic [31:0] quo;
    logic        big;
    logic        zero;
  } div_stage_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    asr = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    sx8 = {{24{v[7]}}, v};
  endfunction

  // One quotient bit: shift in a dividend bit, subtract if it fits
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t  o;
    logic [32:0] trial;
    logic [32:0] diff;
    o     = s;
    trial = {s.rem, s.dvd[31]};
    diff  = trial - {1'b0, s.dvs};
    o.dvd = {s.dvd[30:0], 1'b0};
    if (!diff[32]) begin
      o.rem = diff[31:0];
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = trial[31:0];
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/thp_temp.sv
// ----------------------------------------------------------------------------
// thp_temp
// Four-stage fine temperature pipeline; carries the raw pressure and
// humidity samples alongside so they leave aligned with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_temp
  import thp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] t1,
  input  wire logic [31:0] t2,
  input  wire logic [31:0] t3,
  input  wire logic [19:0] raw_t,
  input  wire logic [19:0] raw_p,
  input  wire logic [15:0] raw_h,
  output logic      [31:0] tf,
  output logic      [19:0] raw_p_o,
  output logic      [15:0] raw_h_o
);

  logic [31:0] s1_a0_r, s1_d_r;
  logic [31:0] s2_m1_r, s2_dd_r;
  logic [31:0] s3_a_r, s3_m2_r;
  logic [31:0] s4_tf_r;
  logic [19:0] rp_r [0:3];
  logic [15:0] rh_r [0:3];

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a0_r <= {15'd0, raw_t[19:3]} - {t1[30:0], 1'b0};
      s1_d_r  <= {16'd0, raw_t[19:4]} - t1;
      s2_m1_r <= s1_a0_r * t2;
      s2_dd_r <= s1_d_r * s1_d_r;
      s3_a_r  <= asr(s2_m1_r, 11);
      s3_m2_r <= asr(s2_dd_r, 12) * t3;
      s4_tf_r <= s3_a_r + asr(s3_m2_r, 14);
    end
  end

  // raw sample alignment
  always_ff @(posedge clk) begin
    if (en) begin
      rp_r[0] <= raw_p;
      rh_r[0] <= raw_h;
      for (int i = 1; i < 4; i++) begin
        rp_r[i] <= rp_r[i-1];
        rh_r[i] <= rh_r[i-1];
      end
    end
  end

  assign tf      = s4_tf_r;
  assign raw_p_o = rp_r[3];
  assign raw_h_o = rh_r[3];

endmodule

`default_nettype wire

FILE: rtl/core/thp_press_pre.sv
// ----------------------------------------------------------------------------
// thp_press_pre
// Six-stage pressure front end: builds the divisor and the dividend from
// the fine temperature and the raw pressure sample.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_press_pre
  import thp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] tf,
  input  wire logic [19:0] raw_p,
  input  wire logic [31:0] p1,
  input  wire logic [31:0] p2,
  input  wire logic [31:0] p3,
  input  wire logic [31:0] p4,
  input  wire logic [31:0] p5,
  input  wire logic [31:0] p6,
  output div_stage_t       div_in
);

  logic [31:0] s1_v1_r, s1_q_r;
  logic [31:0] s2_qq_r, s2_v1p5_r, s2_p2v1_r;
  logic [31:0] s3_v2a_r, s3_t3_r, s3_v1p5_r, s3_p2v1_r;
  logic [31:0] s4_v2_r, s4_w_r;
  logic [31:0] s5_x_r, s5_num_r;
  div_stage_t  s6_r;
  logic [19:0] adc_r [0:3];
  logic [31:0] v2_sum;
  logic [31:0] w_sum;
  logic [31:0] dvs;

  always_comb begin
    v2_sum = s3_v2a_r + {s3_v1p5_r[30:0], 1'b0};
    w_sum  = asr(s3_t3_r, 3) + asr(s3_p2v1_r, 1);
    dvs    = asr(s5_x_r, 15);
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_v1_r   <= asr(tf, 1) - P_TF_OFFSET;
      s1_q_r    <= asr(asr(tf, 1) - P_TF_OFFSET, 2);
      s2_qq_r   <= s1_q_r * s1_q_r;
      s2_v1p5_r <= s1_v1_r * p5;
      s2_p2v1_r <= p2 * s1_v1_r;
      s3_v2a_r  <= asr(s2_qq_r, 11) * p6;
      s3_t3_r   <= p3 * asr(s2_qq_r, 13);
      s3_v1p5_r <= s2_v1p5_r;
      s3_p2v1_r <= s2_p2v1_r;
      s4_v2_r   <= asr(v2_sum, 2) + {p4[15:0], 16'd0};
      s4_w_r    <= asr(w_sum, 18);
      s5_x_r    <= (P_V1_BIAS + s4_w_r) * p1;
      s5_num_r  <= ((P_ADC_BASE - {12'd0, adc_r[3]}) - asr(s4_v2_r, 12)) * P_SCALE;
      // divider entry: small dividends are doubled before the divide
      s6_r.rem  <= '0;
      s6_r.quo  <= '0;
      s6_r.dvs  <= dvs;
      s6_r.zero <= (dvs == '0);
      s6_r.big  <= s5_num_r[31];
      s6_r.dvd  <= s5_num_r[31] ? s5_num_r : {s5_num_r[30:0], 1'b0};
    end
  end

  // raw pressure alignment up to stage five
  always_ff @(posedge clk) begin
    if (en) begin
      adc_r[0] <= raw_p;
      for (int i = 1; i < 4; i++) begin
        adc_r[i] <= adc_r[i-1];
      end
    end
  end

  assign div_in = s6_r;

endmodule

`default_nettype wire

FILE: rtl/core/thp_div.sv
// ----------------------------------------------------------------------------
// thp_div
// 32-stage pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_div
  import thp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire div_stage_t div_in,
  output div_stage_t      div_out
);

  div_stage_t stage_r   [0:31];
  div_stage_t stage_nxt [0:31];

  // next value of every stage
  always_comb begin
    stage_nxt[0] = div_step(div_in);
    for (int k = 1; k < 32; k++) begin
      stage_nxt[k] = div_step(stage_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 32; k++) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  assign div_out = stage_r[31];

endmodule

`default_nettype wire

FILE: rtl/core/thp_press_post.sv
// ----------------------------------------------------------------------------
// thp_press_post
// Three-stage pressure back end: second-order correction of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_press_post
  import thp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire div_stage_t  div_out,
  input  wire logic [31:0] p7,
  input  wire logic [31:0] p8,
  input  wire logic [31:0] p9,
  output logic      [31:0] pressure
);

  logic [31:0] p_val;
  logic [31:0] s1_p_r, s1_a_r, s1_b_r;
  logic        s1_zero_r;
  logic [31:0] s2_p_r, s2_c_r, s2_b_r;
  logic        s2_zero_r;
  logic [31:0] s3_res_r;
  logic [31:0] corr;

  always_comb begin
    p_val = div_out.big ? {div_out.quo[30:0], 1'b0} : div_out.quo;
    corr  = asr(s2_c_r, 12) + asr(s2_b_r, 13) + p7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r    <= p_val;
      s1_a_r    <= {3'd0, p_val[31:3]} * {3'd0, p_val[31:3]};
      s1_b_r    <= {2'd0, p_val[31:2]} * p8;
      s1_zero_r <= div_out.zero;
      s2_p_r    <= s1_p_r;
      s2_c_r    <= p9 * {13'd0, s1_a_r[31:13]};
      s2_b_r    <= s1_b_r;
      s2_zero_r <= s1_zero_r;
      // zero divisor forces a zero result
      s3_res_r  <= s2_zero_r ? '0 : s2_p_r + asr(corr, 4);
    end
  end

  assign pressure = s3_res_r;

endmodule

`default_nettype wire

FILE: rtl/core/thp_hum.sv
// ----------------------------------------------------------------------------
// thp_hum
// Ten-stage humidity pipeline with the final clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_hum
  import thp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] tf,
  input  wire logic [15:0] raw_h,
  input  wire logic [31:0] h1,
  input  wire logic [31:0] h2,
  input  wire logic [31:0] h3,
  input  wire logic [31:0] h4,
  input  wire logic [31:0] h5,
  input  wire logic [31:0] h6,
  output logic      [16:0] hum_q10
);

  logic [31:0] s1_x_r, s1_adc_r;
  logic [31:0] s2_m5_r, s2_xh6_r, s2_xh3_r, s2_adc_r;
  logic [31:0] s3_a_r, s3_b0_r;
  logic [31:0] s4_a_r, s4_b1_r;
  logic [31:0] s5_a_r, s5_b2_r;
  logic [31:0] s6_a_r, s6_b_r;
  logic [31:0] s7_x_r;
  logic [31:0] s8_x_r, s8_ss_r;
  logic [31:0] s9_x_r, s9_m_r;
  logic [16:0] s10_q_r;
  logic [31:0] s7_s;
  logic [31:0] y;
  logic [31:0] y_clamp;

  // final subtract and clamp
  always_comb begin
    s7_s = asr(s7_x_r, 15);
    y    = s9_x_r - asr(s9_m_r, 4);
    if (y[31]) begin
      y_clamp = '0;
    end else if (y > H_CLAMP) begin
      y_clamp = H_CLAMP;
    end else begin
      y_clamp = y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r   <= tf - H_TF_OFFSET;
      s1_adc_r <= {2'd0, raw_h, 14'd0};
      s2_m5_r  <= h5 * s1_x_r;
      s2_xh6_r <= s1_x_r * h6;
      s2_xh3_r <= s1_x_r * h3;
      s2_adc_r <= s1_adc_r;
      s3_a_r   <= asr(s2_adc_r - {h4[11:0], 20'd0} - s2_m5_r + H_ROUND_A, 15);
      s3_b0_r  <= asr(s2_xh6_r, 10) * (asr(s2_xh3_r, 11) + H_BIAS_B);
      s4_a_r   <= s3_a_r;
      s4_b1_r  <= asr(s3_b0_r, 10) + H_BIAS_C;
      s5_a_r   <= s4_a_r;
      s5_b2_r  <= s4_b1_r * h2;
      s6_a_r   <= s5_a_r;
      s6_b_r   <= asr(s5_b2_r + H_ROUND_C, 14);
      s7_x_r   <= s6_a_r * s6_b_r;
      s8_x_r   <= s7_x_r;
      s8_ss_r  <= s7_s * s7_s;
      s9_x_r   <= s8_x_r;
      s9_m_r   <= asr(s8_ss_r, 7) * h1;
      s10_q_r  <= y_clamp[28:12];
    end
  end

  assign hum_q10 = s10_q_r;

endmodule

`default_nettype wire

FILE: rtl/core/sensor_thp_compensation_unit.sv
// ----------------------------------------------------------------------------
// sensor_thp_compensation_unit
// Integer calibration of one raw temperature, pressure and humidity sample
// set per cycle; coefficients are held in configuration registers.
// ----------------------------------------------------------------------------
// Path: input accept to result valid runs through 4 temperature stages,
//   6 pressure front-end stages, 32 divider stages and 3 correction stages.
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds while a valid result waits at the output.
// Reset: synchronous, active low; clears the valid bits and all coefficients.
`default_nettype none

module sensor_thp_compensation_unit
  import thp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [19:0] in_raw_temperature,
  input  wire logic        [19:0] in_raw_pressure,
  input  wire logic        [15:0] in_raw_humidity,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [31:0] out_fine_temperature,
  output logic signed      [31:0] out_temperature_centi,
  output logic             [31:0] out_pressure_pa,
  output logic             [16:0] out_humidity_q10,
  input  wire logic               cfg_wr_en,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [63:0] cfg_wdata
);

  localparam int LATENCY   = 45;
  localparam int TF_DELAY  = 41;
  localparam int HUM_DELAY = 31;

  logic [47:0] temp_r;
  logic [63:0] press_low_r, press_high_r, hum_r;
  logic [15:0] press_nine_r;
  logic [7:0]  hum_six_r;

  logic        en;
  logic        v_r [0:LATENCY-1];
  logic [31:0] tf;
  logic [19:0] raw_p;
  logic [15:0] raw_h;
  logic [31:0] centi;
  logic [31:0] centi_sum;
  div_stage_t  div_in, div_out;
  logic [31:0] pressure;
  logic [16:0] hum_q10;
  logic [31:0] fine_dl_r  [0:TF_DELAY-1];
  logic [31:0] centi_dl_r [0:TF_DELAY-1];
  logic [16:0] hum_dl_r   [0:HUM_DELAY-1];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r       <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_nine_r <= '0;
      hum_r        <= '0;
      hum_six_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TEMP:       temp_r       <= cfg_wdata[47:0];
        CFG_PRESS_LOW:  press_low_r  <= cfg_wdata;
        CFG_PRESS_HIGH: press_high_r <= cfg_wdata;
        CFG_PRESS_NINE: press_nine_r <= cfg_wdata[15:0];
        CFG_HUM:        hum_r        <= cfg_wdata;
        CFG_HUM_SIX:    hum_six_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: hold everything while the output item is not taken
  assign en       = !v_r[LATENCY-1] || out_ready;
  assign in_ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LATENCY; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < LATENCY; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  thp_temp u_temp (
    .clk     (clk),
    .en      (en),
    .t1      ({16'd0, temp_r[15:0]}),
    .t2      (sx16(temp_r[31:16])),
    .t3      (sx16(temp_r[47:32])),
    .raw_t   (in_raw_temperature),
    .raw_p   (in_raw_pressure),
    .raw_h   (in_raw_humidity),
    .tf      (tf),
    .raw_p_o (raw_p),
    .raw_h_o (raw_h)
  );

  thp_press_pre u_press_pre (
    .clk    (clk),
    .en     (en),
    .tf     (tf),
    .raw_p  (raw_p),
    .p1     ({16'd0, press_low_r[15:0]}),
    .p2     (sx16(press_low_r[31:16])),
    .p3     (sx16(press_low_r[47:32])),
    .p4     (sx16(press_low_r[63:48])),
    .p5     (sx16(press_high_r[15:0])),
    .p6     (sx16(press_high_r[31:16])),
    .div_in (div_in)
  );

  thp_div u_div (
    .clk     (clk),
    .en      (en),
    .div_in  (div_in),
    .div_out (div_out)
  );

  thp_press_post u_press_post (
    .clk      (clk),
    .en       (en),
    .div_out  (div_out),
    .p7       (sx16(press_high_r[47:32])),
    .p8       (sx16(press_high_r[63:48])),
    .p9       (sx16(press_nine_r)),
    .pressure (pressure)
  );

  thp_hum u_hum (
    .clk     (clk),
    .en      (en),
    .tf      (tf),
    .raw_h   (raw_h),
    .h1      ({24'd0, hum_r[7:0]}),
    .h2      (sx16(hum_r[23:8])),
    .h3      ({24'd0, hum_r[31:24]}),
    .h4      (sx16(hum_r[47:32])),
    .h5      (sx16(hum_r[63:48])),
    .h6      (sx8(hum_six_r)),
    .hum_q10 (hum_q10)
  );

  // temperature in hundredths: (tf * 5 + 128) >>> 8
  assign centi_sum = {tf[29:0], 2'b00} + tf + T_ROUND;
  assign centi     = asr(centi_sum, 8);

  // alignment of the short paths with the pressure path
  always_ff @(posedge clk) begin
    if (en) begin
      fine_dl_r[0]  <= tf;
      centi_dl_r[0] <= centi;
      hum_dl_r[0]   <= hum_q10;
      for (int i = 1; i < TF_DELAY; i++) begin
        fine_dl_r[i]  <= fine_dl_r[i-1];
        centi_dl_r[i] <= centi_dl_r[i-1];
      end
      for (int i = 1; i < HUM_DELAY; i++) begin
        hum_dl_r[i] <= hum_dl_r[i-1];
      end
    end
  end

  assign out_valid             = v_r[LATENCY-1];
  assign out_fine_temperature  = fine_dl_r[TF_DELAY-1];
  assign out_temperature_centi = centi_dl_r[TF_DELAY-1];
  assign out_pressure_pa       = pressure;
  assign out_humidity_q10      = hum_dl_r[HUM_DELAY-1];

  // checks
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_q10 <= 17'd102400)
    else $error("humidity above full scale");

  a_centi_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature_centi ==
      asr({out_fine_temperature[29:0], 2'b00} + out_fine_temperature + T_ROUND, 8))
    else $error("centi temperature not aligned with fine temperature");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire
